[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define RFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rename free list: property violated");

// As above, with a message chosen at the point of use.
`define RFL_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

[src/rfl_pkg.sv]
// Types, constants and codes shared by the rename free list modules.
package rfl_pkg;

    // Register file dimensions.
    localparam int PHYS_REGS = 64;
    localparam int ARCH_REGS = 32;

    // The list holds every physical register that has no architectural owner.
    localparam int LIST_CAP  = PHYS_REGS - ARCH_REGS;
    localparam int PTR_W     = $clog2(LIST_CAP);
    localparam int ENTRY_W   = 6;
    localparam int COUNT_W   = 6;

    // Operation codes.
    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    // Request word.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_index;
    } req_word_t;

    // Response word.
    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] reg_out;
        logic [COUNT_W-1:0] fill_count;
    } rsp_word_t;

    // Write port of the entry store.
    typedef struct packed {
        logic               en;
        logic [PTR_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } store_wr_t;

endpackage

[src/rfl_store.sv]
// Entry store of the free list: a circular array with one read and one write port.
module rfl_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rfl_pkg::PTR_W-1:0]    rd_addr,
    output logic [rfl_pkg::ENTRY_W-1:0]  rd_data,
    input  rfl_pkg::store_wr_t           wr
);
    import rfl_pkg::*;

    logic [ENTRY_W-1:0] entry_reg [LIST_CAP];

    // Reset fills the list with the registers that have no architectural owner.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_CAP; i++)
            begin
                entry_reg[i] <= ENTRY_W'(ARCH_REGS + i);
            end
        end
        else if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    // The single read port.
    assign rd_data = entry_reg[rd_addr];

endmodule

[src/rfl_ctrl.sv]
// Sequencer of the free list: runs push, pop and the entry-by-entry remove scan.
module rfl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  rfl_pkg::req_word_t           req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output rfl_pkg::rsp_word_t           rsp,
    output logic [rfl_pkg::PTR_W-1:0]    rd_addr,
    input  logic [rfl_pkg::ENTRY_W-1:0]  rd_data,
    output rfl_pkg::store_wr_t           wr
);
    import rfl_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        SCAN,
        SHIFT
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         func_reg, func_next;
    logic [7:0]         idx_reg, idx_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0]   pos_reg, pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic               out_free;
    logic               idx_bad;
    logic [COUNT_W-1:0] pos_inc;
    logic               fin;
    logic [1:0]         fin_status;
    logic [ENTRY_W-1:0] fin_reg;

    assign req_stall = (state_reg != IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The output register can take a new word when empty or being emptied.
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign idx_bad  = (idx_reg >= 8'(PHYS_REGS));
    assign pos_inc  = {1'b0, pos_reg} + COUNT_W'(1);

    // The shift step reads the entry behind the one it overwrites.
    assign rd_addr = head_reg + pos_reg + PTR_W'(state_reg == SHIFT);

    // Next-state and datapath logic.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr             = '0;
        fin            = 1'b0;
        fin_status     = STATUS_OK;
        fin_reg        = '0;

        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    idx_next   = req.reg_index;
                    pos_next   = '0;
                    state_next = EXEC;
                end
            end

            EXEC:
            begin
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (out_free)
                        begin
                            fin = 1'b1;
                            if (idx_bad)
                            begin
                                fin_status = STATUS_INVALID;
                            end
                            else if (occ_reg == COUNT_W'(LIST_CAP))
                            begin
                                fin_status = STATUS_FULL;
                            end
                            else
                            begin
                                wr.en    = 1'b1;
                                wr.addr  = head_reg + occ_reg[PTR_W-1:0];
                                wr.data  = idx_reg[ENTRY_W-1:0];
                                occ_next = occ_reg + COUNT_W'(1);
                            end
                        end
                    end

                    FUNC_POP:
                    begin
                        if (out_free)
                        begin
                            fin = 1'b1;
                            if (occ_reg == '0)
                            begin
                                fin_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                fin_reg   = rd_data;
                                head_next = head_reg + PTR_W'(1);
                                occ_next  = occ_reg - COUNT_W'(1);
                            end
                        end
                    end

                    FUNC_REMOVE:
                    begin
                        if (idx_bad || occ_reg == '0)
                        begin
                            if (out_free)
                            begin
                                fin        = 1'b1;
                                fin_status = idx_bad ? STATUS_INVALID : STATUS_EMPTY;
                            end
                        end
                        else
                        begin
                            state_next = SCAN;
                        end
                    end

                    default:
                    begin
                        // An unused code changes nothing and answers ok.
                        if (out_free)
                        begin
                            fin = 1'b1;
                        end
                    end
                endcase
            end

            SCAN:
            begin
                // One entry is compared per cycle, starting at the head.
                if (rd_data == idx_reg[ENTRY_W-1:0])
                begin
                    state_next = SHIFT;
                end
                else if (pos_inc == occ_reg)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        fin_status = STATUS_EMPTY;
                    end
                end
                else
                begin
                    pos_next = pos_inc[PTR_W-1:0];
                end
            end

            SHIFT:
            begin
                // Close the gap one entry per cycle, then drop the tail.
                if (pos_inc < occ_reg)
                begin
                    wr.en    = 1'b1;
                    wr.addr  = head_reg + pos_reg;
                    wr.data  = rd_data;
                    pos_next = pos_inc[PTR_W-1:0];
                end
                else if (out_free)
                begin
                    fin      = 1'b1;
                    fin_reg  = idx_reg[ENTRY_W-1:0];
                    occ_next = occ_reg - COUNT_W'(1);
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase

        // Load the response word at the end of an operation.
        if (fin)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = fin_status;
            rsp_next.reg_out    = fin_reg;
            rsp_next.fill_count = occ_next;
            state_next          = IDLE;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            func_reg      <= FUNC_PUSH;
            idx_reg       <= '0;
            head_reg      <= '0;
            occ_reg       <= COUNT_W'(LIST_CAP);
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

[src/rename_free_list.sv]
// Push, pop and invalid or unused requests run in the EXEC state, then load the response register.
// Remove scans one entry per cycle from the head, then shifts the later ones down per cycle,
// and at the end loads its result into the response register.
// One word is in flight at a time; the response register lets a new word in while it waits.
// Reset is asynchronous, active low, and leaves registers 32 to 63 in the list, oldest first.
// Top level of the rename free list: sequencer and entry store.
module rename_free_list (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rfl_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rfl_pkg::rsp_word_t rsp
);
    import rfl_pkg::*;

    logic [PTR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    store_wr_t          wr;

    // Sequencer with the comparator and pointers.
    rfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr)
    );

    // Circular entry store.
    rfl_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

endmodule

[src/rfl_checker.sv]
// Port-level checks of the rename free list and the bind that attaches them.
`include "assert_macros.svh"

module rfl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input rfl_pkg::rsp_word_t rsp
);
    import rfl_pkg::*;

    // A stalled response word stays valid and unchanged.
    `RFL_ASSERT(rsp_hold_a, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

    // The block works on one word at a time.
    `RFL_ASSERT(busy_after_accept_a, req_valid && !req_stall |=> req_stall)

    // The list never reports more entries than it can hold.
    `RFL_ASSERT_MSG(fill_bound_a, rsp_valid |-> rsp.fill_count <= COUNT_W'(LIST_CAP),
        "fill count above capacity")

    // A failed operation hands out no register.
    `RFL_ASSERT_MSG(fail_zero_a, rsp_valid && rsp.status != STATUS_OK |-> rsp.reg_out == '0,
        "register handed out on failure")

endmodule

bind rename_free_list rfl_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
